// ===== hdl/rst_pkg.sv =====
// package for the request slot tracker
// shared types, widths and request kind codes; no dependencies
package rst_pkg;
  localparam int SlotCount = 2;
  localparam int SlotW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  localparam logic [3:0] KIND_QUEUE      = 4'd0;
  localparam logic [3:0] KIND_INVALIDATE = 4'd1;
  localparam logic [3:0] KIND_TAKE       = 4'd2;
  localparam logic [3:0] KIND_COMPLETE   = 4'd3;
  localparam logic [3:0] KIND_RETRY      = 4'd4;
  localparam logic [3:0] KIND_RETRY_NC   = 4'd5;
  localparam logic [3:0] KIND_FAIL       = 4'd6;
  localparam logic [3:0] KIND_FAIL_NC    = 4'd7;
  localparam logic [3:0] KIND_QUERY      = 4'd8;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;
  localparam logic [1:0] ST_FAILED  = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  slot_id;
    logic [31:0] owner;
    logic [31:0] current_owner;
    logic [31:0] timestamp;
    logic [31:0] sequence_req;
    logic [31:0] generation;
    logic [63:0] order;
    logic [7:0]  attempt;
    logic        snapshot_present;
  } req_in_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  out_slot;
    logic [31:0] out_generation;
    logic [63:0] out_order;
    logic [31:0] out_owner;
    logic [31:0] out_timestamp;
    logic [31:0] out_sequence;
    logic [7:0]  out_attempt;
    logic [1:0]  slot_status;
    logic        any_pending;
    logic        blocks_read;
  } req_out_t;

  // one slot entry as held in memory
  typedef struct packed {
    logic [31:0] gen;
    logic [31:0] owner;
    logic [1:0]  status;
    logic        snap;
    logic [31:0] r_gen;
    logic [63:0] r_order;
    logic [31:0] r_owner;
    logic [31:0] r_ts;
    logic [31:0] r_seq;
    logic [7:0]  r_attempt;
  } slot_t;
endpackage

// ===== hdl/rst_if.sv =====
// valid/ready channel carrying one payload
// no dependencies
interface rst_req_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/request_slot_tracker_unit.sv =====
// request slot tracker top level: sequencer around the slot memory
// depends on rst_pkg, rst_req_if, rst_slot_mem
// sequence: S_READ issues the slot entry read, S_EXEC applies the request, S_OUT holds the result;
// take next scans every slot in S_SCAN (one memory read per slot scanned) before S_EXEC
// one request at a time: the next is accepted only once the result has been taken
// reset: S_CLEAR first clears the memory slot by slot, no request taken meanwhile
// pending flags and order counter are cleared by rst_ni, max_attempts is reset to 3
module request_slot_tracker_unit
  import rst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rst_req_if.sink    in_if,
  rst_req_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SCAN, S_OUT} state_e;

  state_e           state_q;
  logic [SlotW:0]   cnt_q;
  logic [SlotW-1:0] best_q;
  logic             found_q;
  logic [63:0]      best_order_q;
  logic [7:0]       max_att_q;
  logic [63:0]      next_order_q;
  logic [SlotCount-1:0] pend_q;
  req_in_t          req_q;
  req_out_t         res_q;

  logic             mem_we;
  logic [SlotW-1:0] mem_waddr, mem_raddr;
  slot_t            mem_wdata, rd;

  rst_slot_mem u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(rd)
  );

  logic        in_range;
  logic [31:0] gen_inc;
  logic [63:0] ord_inc;
  logic        match;
  slot_t       nw;
  logic        we_x;
  req_out_t    res_x;
  logic [63:0] ord_x;
  logic [SlotCount-1:0] pend_x;

  assign in_range = 32'(req_q.slot_id) < 32'(SlotCount);
  assign gen_inc  = (rd.gen + 32'd1 == 32'd0) ? 32'd1 : rd.gen + 32'd1;
  assign ord_inc  = (next_order_q + 64'd1 == 64'd0) ? 64'd1 : next_order_q + 64'd1;
  assign match    = req_q.generation == rd.gen && req_q.owner != 32'd0 &&
                    req_q.owner == rd.owner && rd.status == ST_PENDING;

  always_comb begin
    nw     = rd;
    we_x   = 1'b0;
    res_x  = '0;
    ord_x  = next_order_q;
    pend_x = pend_q;
    if (in_range) begin
      case (req_q.kind)
        KIND_QUEUE: begin
          nw = '{gen: gen_inc, owner: req_q.owner, status: ST_PENDING, snap: 1'b0,
                 r_gen: gen_inc, r_order: ord_inc, r_owner: req_q.owner,
                 r_ts: req_q.timestamp, r_seq: req_q.sequence_req, r_attempt: 8'd0};
          we_x = 1'b1;
          ord_x = ord_inc;
          pend_x[req_q.slot_id[SlotW-1:0]] = 1'b1;
          res_x.ok = 1'b1;
          res_x.out_slot = req_q.slot_id;
          res_x.out_generation = gen_inc;
          res_x.out_order = ord_inc;
          res_x.out_owner = req_q.owner;
          res_x.out_timestamp = req_q.timestamp;
          res_x.out_sequence = req_q.sequence_req;
        end
        KIND_INVALIDATE: begin
          nw = '0;
          nw.gen = gen_inc;
          nw.owner = req_q.owner;
          nw.status = ST_IDLE;
          we_x = 1'b1;
          pend_x[req_q.slot_id[SlotW-1:0]] = 1'b0;
          res_x.ok = 1'b1;
          res_x.out_slot = req_q.slot_id;
        end
        KIND_COMPLETE: begin
          if (req_q.snapshot_present && match && req_q.owner == req_q.current_owner) begin
            nw.status = ST_READY;
            nw.snap = 1'b1;
            nw.r_gen = req_q.generation;
            nw.r_order = req_q.order;
            nw.r_owner = req_q.owner;
            nw.r_ts = req_q.timestamp;
            nw.r_seq = req_q.sequence_req;
            nw.r_attempt = req_q.attempt;
            we_x = 1'b1;
            res_x.ok = 1'b1;
          end
        end
        KIND_RETRY, KIND_RETRY_NC: begin
          if (match && (req_q.kind == KIND_RETRY_NC || req_q.owner == req_q.current_owner)
              && req_q.attempt < max_att_q) begin
            nw.r_gen = req_q.generation;
            nw.r_order = ord_inc;
            nw.r_owner = req_q.owner;
            nw.r_ts = req_q.timestamp;
            nw.r_seq = req_q.sequence_req;
            nw.r_attempt = req_q.attempt + 8'd1;
            we_x = 1'b1;
            ord_x = ord_inc;
            pend_x[req_q.slot_id[SlotW-1:0]] = 1'b1;
            res_x.ok = 1'b1;
            res_x.out_slot = req_q.slot_id;
            res_x.out_generation = req_q.generation;
            res_x.out_order = ord_inc;
            res_x.out_owner = req_q.owner;
            res_x.out_timestamp = req_q.timestamp;
            res_x.out_sequence = req_q.sequence_req;
            res_x.out_attempt = req_q.attempt + 8'd1;
          end
        end
        KIND_FAIL, KIND_FAIL_NC: begin
          if (match && (req_q.kind == KIND_FAIL_NC || req_q.owner == req_q.current_owner)) begin
            nw.status = ST_FAILED;
            nw.snap = 1'b0;
            we_x = 1'b1;
            res_x.ok = 1'b1;
          end
        end
        KIND_QUERY: begin
          res_x.ok = rd.status == ST_READY && rd.snap;
          res_x.out_slot = req_q.slot_id;
          res_x.out_owner = rd.owner;
          res_x.out_timestamp = rd.r_ts;
        end
        default: ;
      endcase
      res_x.slot_status = nw.status;
      res_x.blocks_read = nw.status == ST_PENDING || nw.status == ST_FAILED;
    end
    // take next: scan result held in res_q, slot_id entry in rd
    if (req_q.kind == KIND_TAKE && found_q) begin
      pend_x[best_q] = 1'b0;
      res_x.ok = 1'b1;
      res_x.out_slot = res_q.out_slot;
      res_x.out_generation = res_q.out_generation;
      res_x.out_order = res_q.out_order;
      res_x.out_owner = res_q.out_owner;
      res_x.out_timestamp = res_q.out_timestamp;
      res_x.out_sequence = res_q.out_sequence;
      res_x.out_attempt = res_q.out_attempt;
    end
    res_x.any_pending = |pend_x;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_q.slot_id[SlotW-1:0];
    mem_wdata = nw;
    mem_raddr = req_q.slot_id[SlotW-1:0];
    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = cnt_q[SlotW-1:0];
        mem_wdata = '0;
      end
      S_EXEC: mem_we = we_x;
      S_SCAN: begin
        if (32'(cnt_q) == SlotCount - 1) mem_raddr = req_q.slot_id[SlotW-1:0];
        else mem_raddr = cnt_q[SlotW-1:0] + SlotW'(1);
      end
      default: ;
    endcase
    if (state_q == S_READ && req_q.kind == KIND_TAKE) mem_raddr = '0;
  end

  assign in_if.ready  = state_q == S_IDLE;
  assign out_if.valid = state_q == S_OUT;
  assign out_if.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q <= '0;
      best_q <= '0;
      found_q <= 1'b0;
      best_order_q <= '0;
      max_att_q <= 8'd3;
      next_order_q <= '0;
      pend_q <= '0;
      req_q <= '0;
      res_q <= '0;
    end else begin
      if (cfg_we_i) max_att_q <= cfg_wdata_i;
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (32'(cnt_q) == SlotCount - 1) state_q <= S_IDLE;
        end
        S_IDLE: if (in_if.valid) state_q <= S_READ;
        S_READ: begin
          cnt_q <= '0;
          found_q <= 1'b0;
          state_q <= (req_q.kind == KIND_TAKE) ? S_SCAN : S_EXEC;
        end
        S_EXEC: begin
          next_order_q <= ord_x;
          pend_q <= pend_x;
          res_q <= res_x;
          state_q <= S_OUT;
        end
        S_SCAN: begin
          // rd holds slot cnt_q
          if (pend_q[cnt_q[SlotW-1:0]] && (!found_q || rd.r_order < best_order_q)) begin
            found_q <= 1'b1;
            best_q <= cnt_q[SlotW-1:0];
            best_order_q <= rd.r_order;
            res_q.out_slot <= 2'(cnt_q[SlotW-1:0]);
            res_q.out_generation <= rd.r_gen;
            res_q.out_order <= rd.r_order;
            res_q.out_owner <= rd.r_owner;
            res_q.out_timestamp <= rd.r_ts;
            res_q.out_sequence <= rd.r_seq;
            res_q.out_attempt <= rd.r_attempt;
          end
          if (32'(cnt_q) == SlotCount - 1) state_q <= S_EXEC;
          cnt_q <= cnt_q + 1'b1;
        end
        S_OUT: if (out_if.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_IDLE && in_if.valid) req_q <= in_if.data;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("accept while result held");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result dropped");
  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.data.ok && out_if.data.out_order != 64'd0 |-> 1'b0)
    else $error("order without ok");
`endif
endmodule

// ===== hdl/rst_slot_mem.sv =====
// slot entry memory, one write and one registered read port
// depends on rst_pkg
module rst_slot_mem
  import rst_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] waddr_i,
  input  slot_t            wdata_i,
  input  logic [SlotW-1:0] raddr_i,
  output slot_t            rdata_o
);
  slot_t mem_q [SlotCount];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== tb/tb_request_slot_tracker_unit.sv =====
// testbench for the request slot tracker: directed and random requests with a
// per-slot prediction model checked field by field against each response
// depends on rst_pkg, rst_req_if and request_slot_tracker_unit
module tb_request_slot_tracker_unit;
  import rst_pkg::*;

  typedef struct {
    logic [31:0] gen;
    logic [63:0] order;
    logic [31:0] owner;
    logic [31:0] ts;
    logic [31:0] seq;
    logic [7:0]  attempt;
  } held_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;

  rst_req_if #(.payload_t(req_in_t)) in_if ();
  rst_req_if #(.payload_t(req_out_t)) out_if ();

  request_slot_tracker_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_if(in_if.sink),
    .out_if(out_if.source),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // model state
  logic [7:0]  m_max_att;
  logic [31:0] m_gen [SlotCount];
  logic [31:0] m_owner [SlotCount];
  logic [1:0]  m_status [SlotCount];
  logic        m_pend [SlotCount];
  logic        m_snap [SlotCount];
  held_req_t   m_req [SlotCount];
  logic [63:0] m_next_order;

  req_in_t  pending_reqs[$];
  req_out_t expected_resp[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit hold_send = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] bump_order_m();
    m_next_order = m_next_order + 64'd1;
    if (m_next_order == 64'd0) m_next_order = 64'd1;
    return m_next_order;
  endfunction

  function automatic req_out_t predict_response(req_in_t r);
    req_out_t o;
    int s;
    int best;
    bit found;
    bit in_rng;
    bit match;
    held_req_t q;
    o = '0;
    s = r.slot_id;
    in_rng = (r.slot_id < SlotCount);
    match = 1'b0;
    if (in_rng) begin
      match = r.generation == m_gen[s] && r.owner != 32'd0 &&
              r.owner == m_owner[s] && m_status[s] == ST_PENDING;
    end
    if (r.kind == KIND_QUEUE && in_rng) begin
      m_gen[s] = m_gen[s] + 32'd1;
      if (m_gen[s] == 32'd0) m_gen[s] = 32'd1;
      q.gen = m_gen[s];
      q.order = bump_order_m();
      q.owner = r.owner;
      q.ts = r.timestamp;
      q.seq = r.sequence_req;
      q.attempt = 8'd0;
      m_owner[s] = r.owner;
      m_status[s] = ST_PENDING;
      m_pend[s] = 1'b1;
      m_req[s] = q;
      m_snap[s] = 1'b0;
      o.ok = 1'b1;
      o.out_slot = 2'(s);
      o.out_generation = q.gen;
      o.out_order = q.order;
      o.out_owner = q.owner;
      o.out_timestamp = q.ts;
      o.out_sequence = q.seq;
      o.out_attempt = q.attempt;
    end else if (r.kind == KIND_INVALIDATE && in_rng) begin
      m_gen[s] = m_gen[s] + 32'd1;
      if (m_gen[s] == 32'd0) m_gen[s] = 32'd1;
      m_owner[s] = r.owner;
      m_status[s] = ST_IDLE;
      m_pend[s] = 1'b0;
      m_req[s] = '{default: '0};
      m_snap[s] = 1'b0;
      o.ok = 1'b1;
      o.out_slot = 2'(s);
    end else if (r.kind == KIND_TAKE) begin
      found = 1'b0;
      best = 0;
      for (int i = 0; i < SlotCount; i++) begin
        if (m_pend[i] && (!found || m_req[i].order < m_req[best].order)) begin
          found = 1'b1;
          best = i;
        end
      end
      if (found) begin
        m_pend[best] = 1'b0;
        o.ok = 1'b1;
        o.out_slot = 2'(best);
        o.out_generation = m_req[best].gen;
        o.out_order = m_req[best].order;
        o.out_owner = m_req[best].owner;
        o.out_timestamp = m_req[best].ts;
        o.out_sequence = m_req[best].seq;
        o.out_attempt = m_req[best].attempt;
      end
    end else if (r.kind == KIND_COMPLETE && in_rng) begin
      if (r.snapshot_present && match && r.owner == r.current_owner) begin
        m_status[s] = ST_READY;
        m_req[s] = '{r.generation, r.order, r.owner, r.timestamp, r.sequence_req,
                     r.attempt};
        m_snap[s] = 1'b1;
        o.ok = 1'b1;
      end
    end else if ((r.kind == KIND_RETRY || r.kind == KIND_RETRY_NC) && in_rng) begin
      if (match && (r.kind == KIND_RETRY_NC || r.owner == r.current_owner) &&
          r.attempt < m_max_att) begin
        q = '{r.generation, 64'd0, r.owner, r.timestamp, r.sequence_req,
              r.attempt + 8'd1};
        q.order = bump_order_m();
        m_pend[s] = 1'b1;
        m_req[s] = q;
        o.ok = 1'b1;
        o.out_slot = 2'(s);
        o.out_generation = q.gen;
        o.out_order = q.order;
        o.out_owner = q.owner;
        o.out_timestamp = q.ts;
        o.out_sequence = q.seq;
        o.out_attempt = q.attempt;
      end
    end else if ((r.kind == KIND_FAIL || r.kind == KIND_FAIL_NC) && in_rng) begin
      if (match && (r.kind == KIND_FAIL_NC || r.owner == r.current_owner)) begin
        m_status[s] = ST_FAILED;
        m_snap[s] = 1'b0;
        o.ok = 1'b1;
      end
    end else if (r.kind == KIND_QUERY && in_rng) begin
      o.ok = (m_status[s] == ST_READY) && m_snap[s];
      o.out_slot = 2'(s);
      o.out_owner = m_owner[s];
      o.out_timestamp = m_req[s].ts;
    end
    if (in_rng) begin
      o.slot_status = m_status[s];
      o.blocks_read = (m_status[s] == ST_PENDING || m_status[s] == ST_FAILED);
    end
    for (int i = 0; i < SlotCount; i++) begin
      if (m_pend[i]) o.any_pending = 1'b1;
    end
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      expected_resp.push_back(predict_response(in_if.data));
      n_sent <= n_sent + 1;
      in_gap <= $urandom_range(0, 14);
      if (pending_reqs.size() > 0 && !hold_send && $urandom_range(0, 14) == 0) begin
        in_if.valid <= 1'b1;
        in_if.data <= pending_reqs.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end else if (!in_if.valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() > 0 && !hold_send && rst_ni) begin
        in_if.valid <= 1'b1;
        in_if.data <= pending_reqs.pop_front();
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    req_out_t e;
    req_out_t a;
    if (out_if.valid && out_if.ready) begin
      a = out_if.data;
      n_checked <= n_checked + 1;
      if (expected_resp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        e = expected_resp.pop_front();
        if (a.ok !== e.ok) begin
          $error("ok exp %0h got %0h", e.ok, a.ok); errors++;
        end
        if (a.out_slot !== e.out_slot) begin
          $error("out_slot exp %0h got %0h", e.out_slot, a.out_slot); errors++;
        end
        if (a.out_generation !== e.out_generation) begin
          $error("out_generation exp %0h got %0h", e.out_generation, a.out_generation);
          errors++;
        end
        if (a.out_order !== e.out_order) begin
          $error("out_order exp %0h got %0h", e.out_order, a.out_order); errors++;
        end
        if (a.out_owner !== e.out_owner) begin
          $error("out_owner exp %0h got %0h", e.out_owner, a.out_owner); errors++;
        end
        if (a.out_timestamp !== e.out_timestamp) begin
          $error("out_timestamp exp %0h got %0h", e.out_timestamp, a.out_timestamp);
          errors++;
        end
        if (a.out_sequence !== e.out_sequence) begin
          $error("out_sequence exp %0h got %0h", e.out_sequence, a.out_sequence);
          errors++;
        end
        if (a.out_attempt !== e.out_attempt) begin
          $error("out_attempt exp %0h got %0h", e.out_attempt, a.out_attempt); errors++;
        end
        if (a.slot_status !== e.slot_status) begin
          $error("slot_status exp %0h got %0h", e.slot_status, a.slot_status); errors++;
        end
        if (a.any_pending !== e.any_pending) begin
          $error("any_pending exp %0h got %0h", e.any_pending, a.any_pending); errors++;
        end
        if (a.blocks_read !== e.blocks_read) begin
          $error("blocks_read exp %0h got %0h", e.blocks_read, a.blocks_read); errors++;
        end
      end
    end
    if (out_if.ready && !out_if.valid) begin
      out_if.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_if.ready <= 1'b0;
    end else if (out_if.valid && out_if.ready) begin
      out_gap <= $urandom_range(0, 14);
      out_if.ready <= ($urandom_range(0, 14) == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic req_in_t rand_req();
    req_in_t r;
    r.kind = 4'($urandom_range(0, 15));
    r.slot_id = 2'($urandom);
    r.owner = $urandom;
    r.current_owner = $urandom;
    r.timestamp = $urandom;
    r.sequence_req = $urandom;
    r.generation = $urandom;
    r.order = {$urandom, $urandom};
    r.attempt = 8'($urandom);
    r.snapshot_present = 1'($urandom);
    return r;
  endfunction

  // request that addresses the live request of a slot, with owner variants
  function automatic req_in_t follow_up(logic [3:0] k, int s, logic [31:0] gen,
                                        logic [31:0] own, logic [7:0] att);
    req_in_t r;
    r = rand_req();
    r.kind = k;
    r.slot_id = 2'(s);
    r.generation = ($urandom_range(0, 9) == 0) ? $urandom : gen;
    r.owner = own;
    r.current_owner = ($urandom_range(0, 5) == 0) ? $urandom : own;
    r.attempt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : att;
    r.snapshot_present = ($urandom_range(0, 5) != 0);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_if.valid || expected_resp.size() > 0)
      @(posedge clk_i);
    repeat (2 + SlotCount + 4) @(posedge clk_i);
  endtask

  task automatic write_max_attempts(logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    m_max_att = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int s;
    logic [31:0] own;
    logic [31:0] gen [SlotCount];
    logic [31:0] ow [SlotCount];
    logic [7:0] at [SlotCount];
    req_in_t r;
    for (int i = 0; i < SlotCount; i++) begin
      gen[i] = m_gen[i]; ow[i] = m_owner[i]; at[i] = 8'd0;
    end
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(0, SlotCount - 1);
      case ($urandom_range(0, 9))
        0, 1: begin
          r = rand_req();
          r.kind = KIND_QUEUE;
          r.slot_id = 2'(s);
          own = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
          r.owner = own;
          gen[s] = gen[s] + 32'd1;
          if (gen[s] == 32'd0) gen[s] = 32'd1;
          ow[s] = own; at[s] = 8'd0;
        end
        2: begin
          r = rand_req();
          r.kind = KIND_TAKE;
        end
        3, 4: begin
          r = follow_up(($urandom_range(0, 1) == 0) ? KIND_RETRY : KIND_RETRY_NC,
                        s, gen[s], ow[s], at[s]);
          if (r.generation == gen[s] && r.attempt == at[s]) at[s] = at[s] + 8'd1;
        end
        5: r = follow_up(KIND_COMPLETE, s, gen[s], ow[s], at[s]);
        6: r = follow_up(($urandom_range(0, 1) == 0) ? KIND_FAIL : KIND_FAIL_NC,
                         s, gen[s], ow[s], at[s]);
        7: r = follow_up(KIND_QUERY, s, gen[s], ow[s], at[s]);
        8: begin
          r = rand_req();
          if (r.kind == KIND_INVALIDATE && r.slot_id < SlotCount) begin
            gen[r.slot_id] = gen[r.slot_id] + 32'd1;
            if (gen[r.slot_id] == 32'd0) gen[r.slot_id] = 32'd1;
            ow[r.slot_id] = r.owner;
          end
          if (r.kind == KIND_QUEUE && r.slot_id < SlotCount) begin
            gen[r.slot_id] = gen[r.slot_id] + 32'd1;
            if (gen[r.slot_id] == 32'd0) gen[r.slot_id] = 32'd1;
            ow[r.slot_id] = r.owner;
            at[r.slot_id] = 8'd0;
          end
        end
        default: begin
          r = rand_req();
          r.kind = KIND_INVALIDATE;
          r.slot_id = 2'(s);
          gen[s] = gen[s] + 32'd1;
          if (gen[s] == 32'd0) gen[s] = 32'd1;
          ow[s] = r.owner;
        end
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    req_in_t r;
    m_max_att = 8'd3;
    m_next_order = 64'd0;
    for (int i = 0; i < SlotCount; i++) begin
      m_gen[i] = '0; m_owner[i] = '0; m_status[i] = ST_IDLE;
      m_pend[i] = 1'b0; m_snap[i] = 1'b0; m_req[i] = '{default: '0};
    end
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every kind, out of range slot, unknown kind
    r = '0;
    r.kind = KIND_TAKE;
    pending_reqs.push_back(r);
    r = '1;
    r.kind = KIND_QUEUE; r.slot_id = 2'd0;
    pending_reqs.push_back(r);
    r.kind = KIND_QUERY;
    pending_reqs.push_back(r);
    r = '0;
    r.kind = KIND_QUEUE; r.slot_id = 2'd1; r.owner = 32'd7; r.timestamp = 32'd9;
    pending_reqs.push_back(r);
    r.kind = KIND_RETRY; r.generation = 32'd1; r.current_owner = 32'd7;
    r.attempt = 8'd2;
    pending_reqs.push_back(r);
    r.attempt = 8'd3;
    pending_reqs.push_back(r);
    r.kind = KIND_TAKE;
    pending_reqs.push_back(r);
    r.kind = KIND_TAKE;
    pending_reqs.push_back(r);
    r.kind = KIND_TAKE;
    pending_reqs.push_back(r);
    r.kind = KIND_COMPLETE; r.snapshot_present = 1'b1;
    pending_reqs.push_back(r);
    r.kind = KIND_QUERY;
    pending_reqs.push_back(r);
    r = '1;
    r.kind = KIND_FAIL_NC; r.slot_id = 2'd0; r.generation = 32'd1;
    pending_reqs.push_back(r);
    r.kind = KIND_FAIL;
    pending_reqs.push_back(r);
    r.kind = KIND_RETRY_NC; r.attempt = 8'd0;
    pending_reqs.push_back(r);
    r.kind = KIND_QUEUE; r.slot_id = 2'd3;
    pending_reqs.push_back(r);
    r.kind = KIND_QUERY; r.slot_id = 2'd2;
    pending_reqs.push_back(r);
    r.kind = 4'd9;
    pending_reqs.push_back(r);
    r.kind = 4'd15; r.slot_id = 2'd0;
    pending_reqs.push_back(r);
    r = '0;
    r.kind = KIND_INVALIDATE; r.slot_id = 2'd1; r.owner = 32'd5;
    pending_reqs.push_back(r);
    r.kind = KIND_QUERY;
    pending_reqs.push_back(r);
    wait_drained();

    // sender holds off while the random requests are queued, then is released
    hold_send = 1'b1;
    random_phase(20);
    repeat (40) @(posedge clk_i);
    hold_send = 1'b0;
    wait_drained();

    write_max_attempts(8'd0);
    random_phase(400);
    wait_drained();
    write_max_attempts(8'd255);
    random_phase(500);
    wait_drained();
    write_max_attempts(8'd1);
    random_phase(500);
    wait_drained();
    write_max_attempts(8'($urandom_range(2, 254)));
    random_phase(600);
    wait_drained();

    $display("sent %0d requests over five max_attempts settings, %0d responses checked",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/rst_pkg.sv
hdl/rst_if.sv
hdl/rst_slot_mem.sv
hdl/request_slot_tracker_unit.sv
tb/tb_request_slot_tracker_unit.sv
